### src/cwdp_pkg.sv
`timescale 1ns / 1ps
package cwdp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_BITS   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS_ENABLE = 1'd1;

  // Request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ACC  = 1'b1;

  localparam logic [3:0] CODE_BITS_RESET = 4'd4;

  localparam int unsigned CB_W     = 16;
  localparam int unsigned ACT_W    = 16;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned RES_W    = 32;
  localparam int unsigned ROUND_SH = 19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_SCALE,
    ST_FINISH
  } cwdp_state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic prod_en;
    logic acc_en;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic ready;
  } scl_status_t;

endpackage

### src/cwdp_ram.sv
`timescale 1ns / 1ps
module cwdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/cwdp_mac.sv
`timescale 1ns / 1ps
module cwdp_mac #(
  parameter int SUM_WIDTH     = 48,
  parameter int MAX_CODE_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cwdp_pkg::mac_ctrl_t                  ctrl,
  input  logic [MAX_CODE_BITS-1:0]             wr_addr,
  input  logic [cwdp_pkg::CB_W-1:0]            wr_data,
  input  logic [MAX_CODE_BITS-1:0]             rd_addr,
  input  logic signed [cwdp_pkg::ACT_W-1:0]    act,
  output logic signed [SUM_WIDTH-1:0]          sum
);
  import cwdp_pkg::*;

  localparam int DEPTH = 1 << MAX_CODE_BITS;

  logic [CB_W-1:0]          cb_data;
  logic signed [PROD_W-1:0] prod;
  logic [SUM_WIDTH:0]       ext;
  logic                     ovf;
  logic signed [SUM_WIDTH-1:0] sum_next;

  // Entries are written and read only between whole requests, so a read
  // never meets a write to the same entry in flight.
  cwdp_ram #(
    .WIDTH(CB_W),
    .DEPTH(DEPTH)
  ) u_cb_ram (
    .clk  (clk),
    .we   (ctrl.wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (ctrl.rd_en),
    .raddr(rd_addr),
    .rdata(cb_data)
  );

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= $signed(cb_data) * act;
    end
  end

  // Saturating add: two sign bits flag an overflow
  assign ext = (SUM_WIDTH+1)'(sum) + (SUM_WIDTH+1)'(prod);
  assign ovf = ext[SUM_WIDTH] ^ ext[SUM_WIDTH-1];

  always_comb begin
    if (!ovf) begin
      sum_next = ext[SUM_WIDTH-1:0];
    end else if (ext[SUM_WIDTH]) begin
      sum_next = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    end else begin
      sum_next = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.acc_en) begin
      sum <= sum_next;
    end
  end

endmodule

### src/cwdp_scale.sv
`timescale 1ns / 1ps
module cwdp_scale #(
  parameter int SUM_WIDTH = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [SUM_WIDTH-1:0]         sum,
  input  logic [cwdp_pkg::SCALE_W-1:0]        scale,
  input  logic signed [cwdp_pkg::RES_W-1:0]   bias,
  input  logic                                bias_en,
  output cwdp_pkg::scl_status_t               status,
  output logic signed [cwdp_pkg::RES_W-1:0]   res,
  output logic                                res_sat
);
  import cwdp_pkg::*;

  localparam int NCH       = (SUM_WIDTH + 15) / 16;
  localparam int EW        = NCH * 16;
  localparam int AW        = EW + SCALE_W;
  localparam int STEP_W    = $clog2(NCH + 3);
  localparam int LAST_STEP = NCH + 2;

  localparam logic signed [AW-1:0] R_MAX    = AW'(64'sh7FFF_FFFF);
  localparam logic signed [AW-1:0] R_MIN    = ~R_MAX;
  localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (ROUND_SH - 1);

  logic                   busy;
  logic                   ready;
  logic [STEP_W-1:0]      step;
  logic [EW-1:0]          shreg;
  logic [EW-1:0]          src;
  logic [15:0]            chunk;
  logic                   top;
  logic signed [33:0]     mp;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   rnd;
  logic signed [RES_W-1:0] r1;
  logic                   sat1;
  logic signed [RES_W:0]  bsum;

  assign status.busy  = busy;
  assign status.ready = ready;

  // Walk the sum one 16-bit chunk a cycle, most significant first
  assign top   = (step == '0);
  assign src   = top ? EW'(sum) : shreg;
  assign chunk = src[EW-1 -: 16];
  assign rnd   = (acc + RND_HALF) >>> ROUND_SH;
  assign bsum  = (RES_W+1)'(r1) + (bias_en ? (RES_W+1)'(bias) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      ready <= 1'b0;
      step  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      ready <= 1'b0;
      step  <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(LAST_STEP)) begin
        busy  <= 1'b0;
        ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (step < STEP_W'(NCH)) begin
        mp    <= $signed({top & chunk[15], chunk}) * $signed({1'b0, scale});
        shreg <= src << 16;
      end
      if (step == STEP_W'(1)) begin
        acc <= AW'(mp);
      end else if (step > STEP_W'(1) && step <= STEP_W'(NCH)) begin
        acc <= (acc <<< 16) + AW'(mp);
      end
      if (step == STEP_W'(NCH + 1)) begin
        if (rnd > R_MAX) begin
          r1   <= R_MAX[RES_W-1:0];
          sat1 <= 1'b1;
        end else if (rnd < R_MIN) begin
          r1   <= R_MIN[RES_W-1:0];
          sat1 <= 1'b1;
        end else begin
          r1   <= rnd[RES_W-1:0];
          sat1 <= 1'b0;
        end
      end
      if (step == STEP_W'(LAST_STEP)) begin
        if (bsum[RES_W] != bsum[RES_W-1]) begin
          res     <= bsum[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
          res_sat <= 1'b1;
        end else begin
          res     <= bsum[RES_W-1:0];
          res_sat <= sat1;
        end
      end
    end
  end

endmodule

### src/codebook_weight_dot_product.sv
`timescale 1ns / 1ps
// Codebook weight dot product: builds one output element of a matrix-vector
// product whose weights are packed codebook indices. A load request (opcode 0)
// writes one signed Q1.15 entry into the codebook RAM; slots at or beyond
// 2^MAX_CODE_BITS are dropped. An accumulate request (opcode 1) extracts a
// code_bits-wide index from packed_pair at start_bit, reads the codebook
// RAM, multiplies the entry by the Q4.12 activation and adds the product to
// a saturating SUM_WIDTH-bit running sum. An accumulate request passes
// through the RAM read, then the multiply, with the sum update overlapping
// the next request's read. A request marked last then runs the scaling
// sequencer: the sum times the Q8.8 row_scale one 16-bit chunk per cycle,
// rounding half up to Q16.16, saturation, optional bias and a second
// saturation. The result is then loaded into the output register, and only
// after that is the next request taken; the result may then wait there
// while new requests are taken. Codebook entries are undefined until
// loaded; there is no clearing pass after reset. The user must write
// configuration only while the block is idle; the block itself does not
// enforce this.
module codebook_weight_dot_product #(
  parameter int MAX_CODE_BITS = 8,
  parameter int SUM_WIDTH     = 48
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   write_enable,
  input  logic [cwdp_pkg::CFG_INDEX_W-1:0]       write_index,
  input  logic [cwdp_pkg::CFG_DATA_W-1:0]        write_data,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   opcode,
  input  logic [7:0]                             codebook_slot,
  input  logic signed [15:0]                     codebook_value,
  input  logic [15:0]                            packed_pair,
  input  logic [2:0]                             start_bit,
  input  logic signed [15:0]                     activation,
  input  logic                                   last,
  input  logic [15:0]                            row_scale,
  input  logic signed [31:0]                     bias,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [31:0]                     result,
  output logic                                   saturated
);
  import cwdp_pkg::*;

  localparam int IDX_W  = MAX_CODE_BITS;
  localparam int MASK_W = MAX_CODE_BITS + 1;

  cwdp_state_t state;
  cwdp_state_t state_next;

  logic [3:0]  code_bits;
  logic        bias_enable;

  logic                     accept;
  logic                     fin_load;
  logic                     scale_start;
  mac_ctrl_t                mac_ctrl;
  scl_status_t              scl_status;

  logic [3:0]               bits_eff;
  logic [MASK_W-1:0]        mask_full;
  logic [15:0]              shifted;
  logic [IDX_W-1:0]         rd_idx;
  logic                     slot_ok;

  logic signed [ACT_W-1:0]  act_r;
  logic                     last_r;
  logic [SCALE_W-1:0]       scale_r;
  logic signed [RES_W-1:0]  bias_r;

  logic signed [SUM_WIDTH-1:0] sum;
  logic signed [RES_W-1:0]     scl_res;
  logic                        scl_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits   <= CODE_BITS_RESET;
      bias_enable <= 1'b0;
    end else if (write_enable) begin
      case (write_index)
        REG_CODE_BITS:   code_bits   <= write_data;
        REG_BIAS_ENABLE: bias_enable <= write_data[0];
        default: ;
      endcase
    end
  end

  // Index extraction: widths above MAX_CODE_BITS act as MAX_CODE_BITS, and
  // a width of zero selects entry zero.
  assign bits_eff  = (code_bits > 4'(MAX_CODE_BITS)) ? 4'(MAX_CODE_BITS) : code_bits;
  assign mask_full = (MASK_W'(1) << bits_eff) - MASK_W'(1);
  assign shifted   = packed_pair >> start_bit;
  assign rd_idx    = shifted[IDX_W-1:0] & mask_full[IDX_W-1:0];
  assign slot_ok   = (codebook_slot >> MAX_CODE_BITS) == 8'd0;

  // Take a new request when idle, or while the sum update of a non-final
  // term completes.
  assign in_stall = !((state == ST_IDLE) || (state == ST_MAC && !last_r));
  assign accept   = in_valid && !in_stall;

  // Hold the accumulate payload for the rest of the request
  always_ff @(posedge clk) begin
    if (rst) begin
      last_r <= 1'b0;
    end else if (accept && opcode == OP_ACC) begin
      last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_ACC) begin
      act_r   <= activation;
      scale_r <= row_scale;
      bias_r  <= bias;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_ACC) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_MAC;
      ST_MAC: begin
        if (last_r) begin
          state_next = ST_SCALE;
        end else if (accept && opcode == OP_ACC) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCALE: begin
        if (scl_status.ready) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    mac_ctrl    = '0;
    scale_start = 1'b0;
    fin_load    = 1'b0;
    mac_ctrl.wr_en = accept && opcode == OP_LOAD && slot_ok;
    mac_ctrl.rd_en = accept && opcode == OP_ACC;
    case (state)
      ST_READ:   mac_ctrl.prod_en = 1'b1;
      ST_MAC: begin
        mac_ctrl.acc_en = 1'b1;
        scale_start     = last_r;
      end
      ST_FINISH: begin
        fin_load       = !out_valid || !out_stall;
        mac_ctrl.clear = fin_load;
      end
      default: ;
    endcase
  end

  cwdp_mac #(
    .SUM_WIDTH    (SUM_WIDTH),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .wr_addr(codebook_slot[IDX_W-1:0]),
    .wr_data(codebook_value),
    .rd_addr(rd_idx),
    .act    (act_r),
    .sum    (sum)
  );

  cwdp_scale #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (scale_start),
    .sum    (sum),
    .scale  (scale_r),
    .bias   (bias_r),
    .bias_en(bias_enable),
    .status (scl_status),
    .res    (scl_res),
    .res_sat(scl_sat)
  );

  // Output register: parts the result channel from the request side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      result    <= scl_res;
      saturated <= scl_sat;
    end
  end

  // No request may enter while the scaling sequencer runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !scl_status.busy)
    else $error("request accepted while scaling in progress");

  // Drop the running sum once its result is in the output register
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> (sum == '0) && out_valid)
    else $error("running sum not cleared after result");

  // An accepted accumulate request always goes on to its RAM read cycle
  a_acc_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_ACC) |=> state == ST_READ)
    else $error("accumulate request did not advance to read");

  // A finished scaling sequence hands over to the output stage
  a_scale_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE && scl_status.ready) |=> state == ST_FINISH)
    else $error("scaling result not taken");

endmodule
